@@ rtl/core/pdsf_pkg.sv @@
// shared types and constants for the prime and digit-sum filter
// no dependencies

package pdsf_pkg;

  // exact digit sum width: covers ten decimal digits of a 32-bit value
  localparam int SUM_W        = 7;
  localparam int TARGET_W     = 6;
  localparam int OUT_SUM_W    = 6;
  localparam int SUM_MAX      = 63;
  localparam int DEC_BASE     = 10;
  localparam int DIGIT_W      = 4;
  // shift-add-3 binary to bcd: digits at or above 5 get 3 added before a shift
  localparam int BCD_ADJ_MIN  = 5;
  localparam int BCD_ADJ      = 3;
  localparam int FIRST_DIV    = 2;
  localparam int FIRST_SQUARE = FIRST_DIV * FIRST_DIV;

  // controller to datapath
  typedef struct packed {
    logic load;          // capture request number, init candidate
    logic div_start;     // launch the remainder unit on number by candidate
    logic dig_step;      // one bcd conversion or digit accumulation step
    logic cand_next;     // step to next trial divisor
    logic set_composite; // a divisor was found
    logic out_load;      // move result into output register
  } pdsf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic dig_done;
    logic below_two;
    logic sq_over;
    logic rem_zero;
  } pdsf_stat_t;

endpackage

@@ rtl/core/pdsf_divider.sv @@
// bit-serial restoring remainder unit, one dividend bit per cycle
// depends on nothing outside this file

module pdsf_divider #(
  parameter int VALUE_BITS = 20,
  parameter int DVS_W      = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [DVS_W-1:0]      divisor,
  output logic                  done,
  output logic [DVS_W-1:0]      rem
);

  localparam int CNT_W = $clog2(VALUE_BITS + 1);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [VALUE_BITS-1:0] dvd_r, dvd_nxt;
  logic [DVS_W-1:0]      rem_r, rem_nxt;
  logic [DVS_W-1:0]      dvs_r, dvs_nxt;
  logic [DVS_W:0]        trial;
  logic                  fits;

  assign trial = {rem_r, dvd_r[VALUE_BITS-1]};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(VALUE_BITS);
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[VALUE_BITS-2:0], 1'b0};
      rem_nxt = fits ? DVS_W'(trial - {1'b0, dvs_r}) : trial[DVS_W-1:0];
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

@@ rtl/core/pdsf_datapath.sv @@
// datapath: number, bcd digits and their sum, trial divisor and its square, results
// depends on pdsf_pkg and pdsf_divider

module pdsf_datapath #(
  parameter int VALUE_BITS = 20
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [pdsf_pkg::TARGET_W-1:0]  cfg_data,
  input  logic [VALUE_BITS-1:0]          in_number,
  input  pdsf_pkg::pdsf_cmd_t            cmd,
  output pdsf_pkg::pdsf_stat_t           stat,
  output logic                           out_is_prime,
  output logic [pdsf_pkg::OUT_SUM_W-1:0] out_digit_sum,
  output logic                           out_match
);

  import pdsf_pkg::*;

  localparam int D_W   = (VALUE_BITS + 1) / 2 + 2;
  localparam int SQ_W  = VALUE_BITS + 3;
  // decimal digits of the largest VALUE_BITS-bit number
  localparam int ND    = (VALUE_BITS * 3) / 10 + 1;
  localparam int BCD_W = ND * DIGIT_W;
  localparam int CNT_W = $clog2(VALUE_BITS + ND + 1);

  logic [TARGET_W-1:0]   target_r;
  logic [VALUE_BITS-1:0] num_r, work_r;
  logic [BCD_W-1:0]      bcd_r;
  logic [CNT_W-1:0]      dig_cnt_r;
  logic [SUM_W-1:0]      sum_r;
  logic [D_W-1:0]        cand_r;
  logic [SQ_W-1:0]       sq_r;
  logic                  prime_r;
  logic                  res_prime_r, res_match_r;
  logic [OUT_SUM_W-1:0]  res_sum_r;

  logic [BCD_W-1:0]      bcd_adj;
  logic [D_W-1:0]        div_rem;
  logic                  div_done;
  logic [OUT_SUM_W-1:0]  sum_sat;

  pdsf_divider #(
    .VALUE_BITS (VALUE_BITS),
    .DVS_W      (D_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (num_r),
    .divisor  (cand_r),
    .done     (div_done),
    .rem      (div_rem)
  );

  // add 3 to every bcd digit of 5 or more ahead of the next shift
  always_comb begin
    bcd_adj = bcd_r;
    for (int i = 0; i < ND; i++) begin
      if (bcd_r[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(BCD_ADJ_MIN)) begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_r[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(BCD_ADJ);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
    end else if (cfg_we) begin
      target_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num_r     <= in_number;
      work_r    <= in_number;
      bcd_r     <= '0;
      dig_cnt_r <= CNT_W'(VALUE_BITS + ND);
      sum_r     <= '0;
      cand_r    <= D_W'(FIRST_DIV);
      sq_r      <= SQ_W'(FIRST_SQUARE);
      prime_r   <= (in_number >= VALUE_BITS'(FIRST_DIV));
    end else begin
      if (cmd.dig_step) begin
        if (dig_cnt_r > CNT_W'(ND)) begin
          // shift the next binary bit into the bcd digits
          bcd_r  <= {bcd_adj[BCD_W-2:0], work_r[VALUE_BITS-1]};
          work_r <= {work_r[VALUE_BITS-2:0], 1'b0};
        end else begin
          // fold the lowest digit into the sum
          sum_r <= sum_r + SUM_W'(bcd_r[DIGIT_W-1:0]);
          bcd_r <= {{DIGIT_W{1'b0}}, bcd_r[BCD_W-1:DIGIT_W]};
        end
        dig_cnt_r <= dig_cnt_r - CNT_W'(1);
      end
      if (cmd.cand_next) begin
        // (d+1)^2 = d^2 + 2d + 1
        sq_r   <= sq_r + SQ_W'({cand_r, 1'b1});
        cand_r <= cand_r + D_W'(1);
      end
      if (cmd.set_composite) begin
        prime_r <= 1'b0;
      end
    end
  end

  assign sum_sat = (sum_r > SUM_W'(SUM_MAX)) ? OUT_SUM_W'(SUM_MAX) : sum_r[OUT_SUM_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_prime_r <= prime_r;
      res_sum_r   <= sum_sat;
      res_match_r <= prime_r && (sum_r == SUM_W'(target_r));
    end
  end

  assign stat.div_done  = div_done;
  assign stat.dig_done  = (dig_cnt_r == '0);
  assign stat.below_two = (num_r < VALUE_BITS'(FIRST_DIV));
  assign stat.sq_over   = (sq_r > SQ_W'(num_r));
  assign stat.rem_zero  = (div_rem == '0);

  assign out_is_prime  = res_prime_r;
  assign out_digit_sum = res_sum_r;
  assign out_match     = res_match_r;

endmodule

@@ rtl/core/pdsf_ctrl.sv @@
// controller: sequences digit extraction, trial division and result handoff
// depends on pdsf_pkg

module pdsf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  pdsf_pkg::pdsf_stat_t stat,
  output pdsf_pkg::pdsf_cmd_t  cmd
);

  import pdsf_pkg::*;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_DIG     = 3'd1;
  localparam logic [2:0] ST_PR_CHK  = 3'd2;
  localparam logic [2:0] ST_PR_WAIT = 3'd3;
  localparam logic [2:0] ST_DONE    = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DIG;
        end
      end
      ST_DIG: begin
        if (stat.dig_done) begin
          state_nxt = ST_PR_CHK;
        end else begin
          cmd.dig_step = 1'b1;
        end
      end
      ST_PR_CHK: begin
        if (stat.below_two || stat.sq_over) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_PR_WAIT;
        end
      end
      ST_PR_WAIT: begin
        if (stat.div_done) begin
          if (stat.rem_zero) begin
            cmd.set_composite = 1'b1;
            state_nxt         = ST_DONE;
          end else begin
            cmd.cand_next = 1'b1;
            state_nxt     = ST_PR_CHK;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ rtl/core/prime_and_digit_sum_filter.sv @@
// top level of the prime and digit-sum filter
// depends on pdsf_pkg, pdsf_ctrl, pdsf_datapath (with pdsf_divider)

// usage
// - input channel: in_valid / in_ready / in_number carry one request, an
//   unsigned number; it is taken only while the controller sits idle
// - result channel: out_valid / out_ready with out_is_prime, out_digit_sum
//   (saturated at 63) and out_match (prime and exact digit sum == target)
// - cfg_we / cfg_data write the digit-sum target, no wait, reset value 0
// - processing, from the accepting cycle through the handoff: a load, the
//   shift-add-3 conversion of the input bits into decimal digits, one add per
//   digit to sum them plus an exit step, then per trial divisor d = 2, 3 and up
//   a check of d*d against n and a bit-serial remainder, until a divisor is
//   found or the check sees d*d > n (or n below two), then the handoff
// - worst case at VALUE_BITS = 20 (7 digits) is a prime near 2^20: 1022 trial
//   divisions
// - one request is processed at a time; a finished result sits in the output
//   register, and the next request is accepted the cycle after it has moved
//   there, even while the receiver stalls
// - if the receiver stalls with a result already waiting, the next finished
//   result holds in the datapath until the output register frees up
// - synchronous active-low reset returns the controller to idle, drops
//   out_valid and clears the target

module prime_and_digit_sum_filter #(
  parameter int VALUE_BITS = 20
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [pdsf_pkg::TARGET_W-1:0]  cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [VALUE_BITS-1:0]          in_number,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_is_prime,
  output logic [pdsf_pkg::OUT_SUM_W-1:0] out_digit_sum,
  output logic                           out_match
);

  import pdsf_pkg::*;

  // command and status between sequencer and datapath
  pdsf_cmd_t  cmd;
  pdsf_stat_t stat;

  pdsf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pdsf_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .in_number     (in_number),
    .cmd           (cmd),
    .stat          (stat),
    .out_is_prime  (out_is_prime),
    .out_digit_sum (out_digit_sum),
    .out_match     (out_match)
  );

endmodule

@@ dv/prime_and_digit_sum_filter_test.sv @@
`timescale 1ns / 100ps
// self-checking testbench for prime_and_digit_sum_filter: directed and random numbers,
// each result checked against a trial-division and digit-sum predictor kept here
// depends on pdsf_pkg and the prime_and_digit_sum_filter rtl

module prime_and_digit_sum_filter_test;
  import pdsf_pkg::*;

  localparam int VALUE_BITS = 20;
  localparam int NUMBER_MAX = (1 << VALUE_BITS) - 1;
  // receiver hold-off long enough to fill the output register and the datapath
  localparam int LONG_HOLD = 3000;
  // worst correct gap between handshakes is one prime near 2^20
  // plus the long hold-off; allow several times that
  localparam int QUIET_LIMIT = 100000;
  // after the last result, wait out one worst-case request for a stray result
  localparam int TAIL_CYCLES = 25000;
  localparam int REPORT_CAP = 100;

  typedef struct packed {
    logic                 is_prime;
    logic [OUT_SUM_W-1:0] digit_sum;
    logic                 match;
  } verdict_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [TARGET_W-1:0]   cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [VALUE_BITS-1:0] in_number = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_is_prime;
  logic [OUT_SUM_W-1:0]  out_digit_sum;
  logic                  out_match;

  // numbers waiting to be offered, and verdicts waiting for their result
  logic [VALUE_BITS-1:0] numbers_to_send[$];
  verdict_t              pending_verdicts[$];

  logic [TARGET_W-1:0] target_copy = '0;
  bit  idle_enable = 1'b1;
  int  hold_req = 0;
  int  hold_seen = 0;
  int  hold_left = 0;
  int  stall_left = 0;
  int  send_gap = 0;
  int  requests_total = 0;
  int  results_seen = 0;
  int  error_count = 0;
  int  quiet_cycles = 0;

  prime_and_digit_sum_filter #(
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_number    (in_number),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_is_prime (out_is_prime),
    .out_digit_sum(out_digit_sum),
    .out_match    (out_match)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // expected verdict for one number: trial division while d*d <= n, decimal digit
  // sum saturated for the port, match against the exact sum
  function automatic verdict_t screen_number(logic [VALUE_BITS-1:0] number,
                                             logic [TARGET_W-1:0] target);
    longint unsigned n;
    longint unsigned d;
    longint unsigned rest;
    longint unsigned sum;
    bit              prime;
    verdict_t        v;
    n = number;
    prime = (n >= 2);
    for (d = 2; prime && d * d <= n; d++) begin
      if (n % d == 0) prime = 1'b0;
    end
    sum = 0;
    rest = n;
    while (rest > 0) begin
      sum += rest % DEC_BASE;
      rest /= DEC_BASE;
    end
    v.is_prime = prime;
    v.digit_sum = (sum > SUM_MAX) ? OUT_SUM_W'(SUM_MAX) : OUT_SUM_W'(sum);
    v.match = prime && (sum == target);
    return v;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    error_count++;
    if (error_count <= REPORT_CAP)
      $display("mismatch on result %0d, %0s: got %0d, expected %0d",
               results_seen, what, got, want);
  endtask

  // mirror of the target register, written only while the block is idle
  always @(posedge clk) begin
    if (!rst_n) begin
      target_copy <= '0;
    end else if (cfg_we) begin
      target_copy <= cfg_data;
    end
  end

  // request driver: offers queued numbers, predicts each one as it is taken
  always @(posedge clk) begin
    logic busy;
    busy = in_valid;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        pending_verdicts.push_back(screen_number(in_number, target_copy));
        busy = 1'b0;
      end
      if (!busy) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (numbers_to_send.size() != 0) begin
          in_valid <= 1'b1;
          in_number <= numbers_to_send.pop_front();
          // idle burst after this request is taken
          if (idle_enable && $urandom_range(0, 3) == 0) send_gap <= $urandom_range(1, 4);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
      hold_seen <= 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_verdicts.size() == 0) begin
          report_mismatch("result with no request outstanding", 1, 0);
        end else begin
          want = pending_verdicts.pop_front();
          if (out_is_prime !== want.is_prime)
            report_mismatch("is_prime", out_is_prime, want.is_prime);
          if (out_digit_sum !== want.digit_sum)
            report_mismatch("digit_sum", out_digit_sum, want.digit_sum);
          if (out_match !== want.match)
            report_mismatch("match", out_match, want.match);
        end
      end
      if (hold_req != hold_seen) begin
        // long hold-off, counted down here while the driver keeps offering
        hold_seen <= hold_req;
        hold_left <= LONG_HOLD;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
        // random stall burst
        stall_left <= $urandom_range(0, 3);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog: too long without any handshake on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_number(logic [VALUE_BITS-1:0] number);
    numbers_to_send.push_back(number);
    requests_total++;
  endtask

  // sender pause: nothing more until every result is back, then the handoff settles
  task automatic wait_all_results();
    while (results_seen < requests_total) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_target(logic [TARGET_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // random number mix: many cheap small values, some up to 16 bits, some full range,
  // some squares, some near the top, and some primes picked to hit the target digit sum
  task automatic queue_random(int count, logic [TARGET_W-1:0] target);
    logic [VALUE_BITS-1:0] pick;
    verdict_t              v;
    int                    k;
    int                    tries;
    for (k = 0; k < count; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: pick = VALUE_BITS'($urandom_range(0, 3000));
        4, 5:       pick = VALUE_BITS'($urandom_range(0, 65535));
        6, 7:       pick = VALUE_BITS'($urandom_range(0, NUMBER_MAX));
        8: begin
          pick = VALUE_BITS'($urandom_range(0, 3000));
          for (tries = 0; tries < 400; tries++) begin
            v = screen_number(pick, target);
            if (v.match) break;
            pick = VALUE_BITS'($urandom_range(0, 3000));
          end
        end
        default: begin
          if ($urandom_range(0, 1)) begin
            pick = VALUE_BITS'(NUMBER_MAX - $urandom_range(0, 64));
          end else begin
            tries = $urandom_range(2, 1023);
            pick = VALUE_BITS'(tries * tries);
          end
        end
      endcase
      queue_number(pick);
    end
  endtask

  initial begin
    logic [TARGET_W-1:0] tgt;
    int k;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed, target at its reset value: below two, smallest primes, prime squares
    // (d*d equal to n), all-zero and all-one inputs, largest digit sum, big primes
    queue_number(0);
    queue_number(1);
    queue_number(2);
    queue_number(3);
    queue_number(4);
    queue_number(9);
    queue_number(25);
    queue_number(121);
    queue_number(1042441);  // 1021 squared
    queue_number(999999);
    queue_number(999983);
    queue_number(NUMBER_MAX);
    queue_number(1048573);
    queue_number(524287);
    wait_all_results();

    // digit sum 28 matches the two large primes
    write_target(28);
    queue_number(1048573);
    queue_number(524287);
    queue_number(NUMBER_MAX);
    queue_number(37);
    queue_number(1);
    wait_all_results();

    write_target(2);
    queue_number(2);
    queue_number(11);
    queue_number(101);
    queue_number(20);
    queue_number(200);
    wait_all_results();

    // top of the target range, no number of this width can match it
    write_target(63);
    queue_random(25, 63);
    wait_all_results();

    // long receiver hold-off with cheap requests, so the block backs up
    tgt = TARGET_W'($urandom_range(4, 20));
    write_target(tgt);
    hold_req <= hold_req + 1;
    for (k = 0; k < 12; k++) queue_number(VALUE_BITS'($urandom_range(0, 300)));
    wait_all_results();

    tgt = TARGET_W'($urandom_range(1, 30));
    write_target(tgt);
    queue_random(30, tgt);
    wait_all_results();

    // last stretch: no idling on either side, first with the target back at zero, then a random target
    write_target(0);
    idle_enable <= 1'b0;
    queue_random(10, 0);
    wait_all_results();
    tgt = TARGET_W'($urandom_range(5, 25));
    write_target(tgt);
    queue_random(20, tgt);
    wait_all_results();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_verdicts.size() != 0) begin
      error_count++;
      $display("%0d results never arrived", pending_verdicts.size());
    end
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
